### design/assert_macros.svh
// Assertion macros for the box filter RTL, used by the top level.
// Depends on nothing; the checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bf3 same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bf3 next-cycle check failed");

`else

`define BF3_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define BF3_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### design/bf3_pkg.sv
// Package for the 3x3 RGB box filter: payload types, widths and constants.
// Used by every module of the block except bf3_ram; depends on nothing.
`timescale 1ns / 1ps

package bf3_pkg;

    // Fixed data widths.
    localparam int CHANNEL_BITS    = 8;
    localparam int MAX_WIDTH       = 2048;
    localparam int LINE_WIDTH_BITS = 12;
    localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 12'd640;
    localparam int ROW_BITS        = 16;
    localparam int TAPS            = 9;
    localparam int LANES           = 3;

    // Divide by nine: multiply by ceil(2^16 / 9) and keep bits 23..16.
    // Exact for every sum below 32768; the largest sum is 9 * 255.
    localparam int SUM_BITS    = 12;
    localparam int RECIP_BITS  = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_9 = 13'd7282;

    // Output queue and the number of stages an item spends before reaching it.
    localparam int OQ_DEPTH    = 8;
    localparam int PIPE_STAGES = 4;

    // One pixel: channel 0 in the low bits.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] c;
        logic [CHANNEL_BITS-1:0] b;
        logic [CHANNEL_BITS-1:0] a;
    } bf3_pix_t;

    // 3x3 window, index = row * 3 + column (rows upper, middle, current).
    typedef bf3_pix_t [TAPS-1:0] bf3_win_t;

    // Nine samples of one channel.
    typedef logic [TAPS-1:0][CHANNEL_BITS-1:0] bf3_taps_t;

    // Input transaction payload.
    typedef struct packed {
        logic                    frame_start;
        logic [CHANNEL_BITS-1:0] chan_a_in;
        logic [CHANNEL_BITS-1:0] chan_b_in;
        logic [CHANNEL_BITS-1:0] chan_c_in;
    } bf3_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] chan_a_mean;
        logic [CHANNEL_BITS-1:0] chan_b_mean;
        logic [CHANNEL_BITS-1:0] chan_c_mean;
        logic                    row_end;
    } bf3_out_t;

    // Control that travels alongside the lane pipelines.
    typedef struct packed {
        logic valid;
        logic row_end;
    } bf3_ctl_t;

    // Row counter increment that saturates at all ones.
    function automatic logic [ROW_BITS-1:0] row_sat_inc(input logic [ROW_BITS-1:0] r);
        return (&r) ? r : r + ROW_BITS'(1);
    endfunction

endpackage

### design/bf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the line stores of the box filter.
`timescale 1ns / 1ps

module bf3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read and write to one address in a cycle returns the old word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/bf3_window.sv
// Raster position tracking, two line stores and the 3x3 window registers.
// Depends on bf3_pkg and bf3_ram.
`timescale 1ns / 1ps

module bf3_window #(
    parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_accept,
    input  bf3_pkg::bf3_in_t                     in_data,
    input  logic [bf3_pkg::LINE_WIDTH_BITS-1:0]  line_width,
    output logic                                 s1_busy,
    output bf3_pkg::bf3_win_t                    win,
    output bf3_pkg::bf3_ctl_t                    win_ctl
);

    localparam int CAW = $clog2(MAX_WIDTH);
    localparam int EW0 = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (EW0 > bf3_pkg::LINE_WIDTH_BITS) ? EW0 : bf3_pkg::LINE_WIDTH_BITS;
    localparam int RB  = bf3_pkg::ROW_BITS;

    logic [CAW-1:0]  col_reg, col_next;
    logic [RB-1:0]   row_reg, row_next;
    logic [EW-1:0]   eff_w, lw_ext, col_inc;
    logic [CAW-1:0]  col_a, col_b;
    logic [RB-1:0]   row_a, row_b;
    logic            emit, row_end;
    bf3_pkg::bf3_pix_t pix;

    logic              s1_valid_reg;
    logic [CAW-1:0]    s1_col_reg;
    bf3_pkg::bf3_pix_t s1_pix_reg;
    logic              s1_emit_reg;
    logic              s1_row_end_reg;
    logic              byp_hit_reg;
    bf3_pkg::bf3_pix_t byp_data_reg;

    bf3_pkg::bf3_pix_t up_rd, mid_rd, up_val;
    bf3_pkg::bf3_win_t win_reg, win_next;
    bf3_pkg::bf3_ctl_t win_ctl_reg;

    // Clamp the configured width into the supported range.
    always_comb begin
        lw_ext = EW'(line_width);
        if (lw_ext < EW'(3)) begin
            eff_w = EW'(3);
        end else if (lw_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = lw_ext;
        end
    end

    // Position of the incoming pixel and the position after it.
    always_comb begin
        col_a = in_data.frame_start ? '0 : col_reg;
        row_a = in_data.frame_start ? '0 : row_reg;
        if (EW'(col_a) >= eff_w) begin
            col_b = '0;
            row_b = bf3_pkg::row_sat_inc(row_a);
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
        col_inc = EW'(col_b) + EW'(1);
        if (col_inc >= eff_w) begin
            col_next = '0;
            row_next = bf3_pkg::row_sat_inc(row_b);
        end else begin
            col_next = col_inc[CAW-1:0];
            row_next = row_b;
        end
        emit    = (row_b >= RB'(2)) && (col_b >= CAW'(2));
        row_end = (EW'(col_b) == eff_w - EW'(1));
    end

    assign pix.a = in_data.chan_a_in;
    assign pix.b = in_data.chan_b_in;
    assign pix.c = in_data.chan_c_in;

    // Position counters advance once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Middle store takes the new pixel now; its old word moves to the upper store
    // in the next cycle, once the read data is back.
    bf3_ram #(.WIDTH($bits(bf3_pkg::bf3_pix_t)), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .aclk    (aclk),
        .wr_en   (in_accept),
        .wr_addr (col_b),
        .wr_data (pix),
        .rd_en   (in_accept),
        .rd_addr (col_b),
        .rd_data (mid_rd)
    );

    bf3_ram #(.WIDTH($bits(bf3_pkg::bf3_pix_t)), .DEPTH(MAX_WIDTH)) u_up_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (mid_rd),
        .rd_en   (in_accept),
        .rd_addr (col_b),
        .rd_data (up_rd)
    );

    // Stage 1 control, with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
        end
    end

    // Stage 1 payload. The bypass covers an upper-store write that lands on the
    // same edge as a read of the same column.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_col_reg     <= col_b;
            s1_pix_reg     <= pix;
            s1_emit_reg    <= emit;
            s1_row_end_reg <= row_end;
            byp_hit_reg    <= s1_valid_reg && (s1_col_reg == col_b);
            byp_data_reg   <= mid_rd;
        end
    end

    assign up_val = byp_hit_reg ? byp_data_reg : up_rd;

    // Window columns shift left; the new column enters on the right.
    always_comb begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up_val;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_rd;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            win_ctl_reg <= '0;
        end else begin
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
            win_ctl_reg.valid   <= s1_valid_reg && s1_emit_reg;
            win_ctl_reg.row_end <= s1_row_end_reg;
        end
    end

    assign s1_busy = s1_valid_reg;
    assign win     = win_reg;
    assign win_ctl = win_ctl_reg;

endmodule

### design/bf3_lane.sv
// One channel lane: sums the nine window samples and divides by nine.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_lane (
    input  logic                               aclk,
    input  bf3_pkg::bf3_taps_t                 taps,
    output logic [bf3_pkg::CHANNEL_BITS-1:0]   mean
);

    localparam int SB = bf3_pkg::SUM_BITS;

    logic [SB-1:0]                  row0, row1, row2;
    logic [SB-1:0]                  sum_reg;
    logic [bf3_pkg::PROD_BITS-1:0]  prod_reg;

    // Three row sums feed one final add.
    always_comb begin
        row0 = SB'(taps[0]) + SB'(taps[1]) + SB'(taps[2]);
        row1 = SB'(taps[3]) + SB'(taps[4]) + SB'(taps[5]);
        row2 = SB'(taps[6]) + SB'(taps[7]) + SB'(taps[8]);
    end

    // Sum register, then the reciprocal multiply register.
    always_ff @(posedge aclk) begin
        sum_reg  <= row0 + row1 + row2;
        prod_reg <= bf3_pkg::PROD_BITS'(sum_reg) * bf3_pkg::PROD_BITS'(bf3_pkg::RECIP_9);
    end

    assign mean = prod_reg[bf3_pkg::RECIP_SHIFT +: bf3_pkg::CHANNEL_BITS];

endmodule

### design/bf3_merge.sv
// Merging stage: joins the three lane means and row flag into one result and
// queues it for the output channel. Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_merge (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  bf3_pkg::bf3_ctl_t                       ctl,
    input  logic [bf3_pkg::CHANNEL_BITS-1:0]        mean_a,
    input  logic [bf3_pkg::CHANNEL_BITS-1:0]        mean_b,
    input  logic [bf3_pkg::CHANNEL_BITS-1:0]        mean_c,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output bf3_pkg::bf3_out_t                       m_data,
    output logic [$clog2(bf3_pkg::OQ_DEPTH+1)-1:0]  count
);

    localparam int DEPTH = bf3_pkg::OQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    bf3_pkg::bf3_out_t q_mem [DEPTH];
    bf3_pkg::bf3_out_t wr_word;
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_wr, do_rd;

    // Compose the result transaction.
    always_comb begin
        wr_word.chan_a_mean = mean_a;
        wr_word.chan_b_mean = mean_b;
        wr_word.chan_c_mean = mean_c;
        wr_word.row_end     = ctl.row_end;
    end

    assign do_wr = ctl.valid;
    assign do_rd = m_valid && m_ready;

    // Queue storage; room is guaranteed by the input credit check.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            q_mem[wr_ptr_reg] <= wr_word;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = q_mem[rd_ptr_reg];
    assign count   = count_reg;

endmodule

### design/box_filter_3x3_rgb_top.sv
// Throughput: one pixel per cycle unless s_ready is low, set by one read and one write
// of each line store per pixel and by the three channel lanes, which each take a new
// window every cycle. s_ready stays high while the eight-entry output queue plus
// in-flight results has room. Reset (aresetn, synchronous, active low) clears the
// counters, window and queue and sets line_width to 640; line store contents are left
// undefined.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module box_filter_3x3_rgb_top #(
    parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bf3_pkg::bf3_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bf3_pkg::bf3_out_t                    m_data,
    input  logic                                 cfg_wr_en,
    input  logic [bf3_pkg::LINE_WIDTH_BITS-1:0]  cfg_wr_data
);

    localparam int DEPTH = bf3_pkg::OQ_DEPTH;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OW    = $clog2(DEPTH + bf3_pkg::PIPE_STAGES + 1);

    logic [bf3_pkg::LINE_WIDTH_BITS-1:0] line_width_reg;
    logic                                in_accept;
    logic                                s1_busy;
    bf3_pkg::bf3_win_t                   win;
    bf3_pkg::bf3_ctl_t                   win_ctl, s3_ctl_reg, s4_ctl_reg;
    bf3_pkg::bf3_taps_t                  lane_taps [bf3_pkg::LANES];
    logic [bf3_pkg::CHANNEL_BITS-1:0]    lane_mean [bf3_pkg::LANES];
    logic [CW-1:0]                       q_count;
    logic [OW-1:0]                       occ;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= bf3_pkg::LINE_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            line_width_reg <= cfg_wr_data;
        end
    end

    // Credit: queued results plus every transaction still in the pipeline.
    assign occ = OW'(q_count) + OW'(s1_busy) + OW'(win_ctl.valid)
               + OW'(s3_ctl_reg.valid) + OW'(s4_ctl_reg.valid);
    assign s_ready   = (occ < OW'(DEPTH));
    assign in_accept = s_valid && s_ready;

    bf3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_data    (s_data),
        .line_width (line_width_reg),
        .s1_busy    (s1_busy),
        .win        (win),
        .win_ctl    (win_ctl)
    );

    // Split the window into one tap set per channel.
    always_comb begin
        for (int k = 0; k < bf3_pkg::TAPS; k++) begin
            lane_taps[0][k] = win[k].a;
            lane_taps[1][k] = win[k].b;
            lane_taps[2][k] = win[k].c;
        end
    end

    for (genvar g = 0; g < bf3_pkg::LANES; g++) begin : g_lane
        bf3_lane u_lane (
            .aclk (aclk),
            .taps (lane_taps[g]),
            .mean (lane_mean[g])
        );
    end

    // Control follows the two lane stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end else begin
            s3_ctl_reg <= win_ctl;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    bf3_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (s4_ctl_reg),
        .mean_a  (lane_mean[0]),
        .mean_b  (lane_mean[1]),
        .mean_c  (lane_mean[2]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .count   (q_count)
    );

    // The credit check must keep the output queue from ever overflowing.
    `BF3_ASSERT_IMPLY(a_credit_bound, aclk, aresetn, 1'b1, occ <= OW'(DEPTH))
    // An accepted transaction always occupies stage one on the next cycle.
    `BF3_ASSERT_NEXT(a_accept_tracked, aclk, aresetn, in_accept, s1_busy)
    // A result leaving the lanes is offered on the output next cycle.
    `BF3_ASSERT_NEXT(a_result_offered, aclk, aresetn, s4_ctl_reg.valid, m_valid)

endmodule

### dv/testbench.sv
// Self-checking testbench for the 3x3 RGB box filter (box_filter_3x3_rgb_top).
// Depends on bf3_pkg and the top level; a behavioral predictor of the line stores and the
// window works out every mean, and a checker compares each result transaction with it.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = bf3_pkg::PIPE_STAGES + 8;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 380;
    localparam int REPORT_CAP    = 100;
    localparam int ROW_LIMIT     = 65535;
    localparam int MIN_WIDTH     = 3;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    bf3_pkg::bf3_in_t                    s_data;
    logic                                m_valid;
    logic                                m_ready;
    bf3_pkg::bf3_out_t                   m_data;
    logic                                cfg_wr_en;
    logic [bf3_pkg::LINE_WIDTH_BITS-1:0] cfg_wr_data;

    // Predictor state: a private copy of the register, line stores, window and counters.
    logic [bf3_pkg::LINE_WIDTH_BITS-1:0] width_reg;
    bf3_pkg::bf3_pix_t                   upper_row [bf3_pkg::MAX_WIDTH];
    bf3_pkg::bf3_pix_t                   middle_row [bf3_pkg::MAX_WIDTH];
    bf3_pkg::bf3_pix_t                   window [bf3_pkg::TAPS];
    int                                  col_count;
    int                                  row_count;
    bf3_pkg::bf3_out_t                   mean_queue [$];
    bf3_pkg::bf3_out_t                   oldest_mean;

    // Run control shared by the stimulus, the receiver and the checker.
    int   mismatches    = 0;
    int   cycle_count   = 0;
    int   hold_requests;
    int   holds_served  = 0;
    int   src_calm      = 0;
    int   sink_calm     = 0;
    int   sink_stall    = 0;
    logic quiet_src;
    logic quiet_sink;

    always #CLK_HALF aclk = ~aclk;

    box_filter_3x3_rgb_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Row width the block actually uses: the register clamped to the legal range.
    function automatic int active_width();
        if (width_reg < MIN_WIDTH) return MIN_WIDTH;
        if (width_reg > bf3_pkg::MAX_WIDTH) return bf3_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic void advance_row();
        col_count = 0;
        if (row_count < ROW_LIMIT) row_count++;
    endfunction

    // Take one accepted pixel and queue the mean it produces, if any.
    function automatic void predict_mean(input bf3_pkg::bf3_in_t px);
        int                w;
        int                col;
        int                k;
        int                sum_a;
        int                sum_b;
        int                sum_c;
        bf3_pkg::bf3_pix_t pix;
        bf3_pkg::bf3_pix_t up;
        bf3_pkg::bf3_pix_t mid;
        bf3_pkg::bf3_out_t res;
        w = active_width();
        if (px.frame_start) begin
            col_count = 0;
            row_count = 0;
        end
        // A row left longer than the current width counts as finished.
        if (col_count >= w) advance_row();
        col = col_count;
        pix.a = px.chan_a_in;
        pix.b = px.chan_b_in;
        pix.c = px.chan_c_in;
        up  = upper_row[col];
        mid = middle_row[col];
        upper_row[col]  = mid;
        middle_row[col] = pix;
        // Window rows are upper, middle and current; the columns shift left.
        for (k = 0; k < bf3_pkg::TAPS; k += 3) begin
            window[k]     = window[k + 1];
            window[k + 1] = window[k + 2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = pix;
        if (row_count >= 2 && col >= 2) begin
            sum_a = 0;
            sum_b = 0;
            sum_c = 0;
            for (k = 0; k < bf3_pkg::TAPS; k++) begin
                sum_a += window[k].a;
                sum_b += window[k].b;
                sum_c += window[k].c;
            end
            res.chan_a_mean = bf3_pkg::CHANNEL_BITS'(sum_a / bf3_pkg::TAPS);
            res.chan_b_mean = bf3_pkg::CHANNEL_BITS'(sum_b / bf3_pkg::TAPS);
            res.chan_c_mean = bf3_pkg::CHANNEL_BITS'(sum_c / bf3_pkg::TAPS);
            res.row_end     = (col == w - 1);
            mean_queue.push_back(res);
        end
        col_count = col + 1;
        if (col_count >= w) advance_row();
    endfunction

    // Mostly random samples, with the two extremes favored.
    function automatic logic [bf3_pkg::CHANNEL_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return bf3_pkg::CHANNEL_BITS'($urandom);
    endfunction

    // A negative fill gives random samples; otherwise every channel holds the fill.
    function automatic bf3_pkg::bf3_in_t pick_pixel(input logic restart, input int fill);
        bf3_pkg::bf3_in_t px;
        px.frame_start = restart;
        if (fill < 0) begin
            px.chan_a_in = pick_sample();
            px.chan_b_in = pick_sample();
            px.chan_c_in = pick_sample();
        end else begin
            px.chan_a_in = bf3_pkg::CHANNEL_BITS'(fill);
            px.chan_b_in = bf3_pkg::CHANNEL_BITS'(fill);
            px.chan_c_in = bf3_pkg::CHANNEL_BITS'(fill);
        end
        return px;
    endfunction

    // Idle length: mostly none or short, a few long, and now and then a calm stretch.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string field, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
        end
    endfunction

    // Offer one pixel until the block takes it, then idle for a random gap.
    task automatic push_pixel(input bf3_pkg::bf3_in_t px);
        int gap;
        s_data  <= px;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_mean(px);
        gap = quiet_src ? 0 : pick_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic push_run(input int count, input int fill, input logic restart);
        int i;
        for (i = 0; i < count; i++) push_pixel(pick_pixel(restart && i == 0, fill));
    endtask

    // Stop offering, wait for every expected mean, then let the pipeline empty.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (mean_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [bf3_pkg::LINE_WIDTH_BITS-1:0] w);
        drain_results();
        cfg_wr_data <= w;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
    endtask

    // The first frame begins at reset without a frame start, at the reset width.
    // A short run at that width ends no row and so yields no mean.
    task automatic test_reset_width();
        push_run(40, -1, 1'b0);
    endtask

    // Narrowest rows with all-ones, all-zeros and random frames.
    task automatic test_flat_frames();
        write_width(bf3_pkg::LINE_WIDTH_BITS'(MIN_WIDTH));
        push_run(5 * MIN_WIDTH, 255, 1'b1);
        push_run(5 * MIN_WIDTH, 0, 1'b1);
        push_run(4 * MIN_WIDTH, -1, 1'b1);
    endtask

    // Widths below the minimum act as the minimum.
    task automatic test_width_floor();
        int w;
        for (w = 0; w < MIN_WIDTH; w++) begin
            write_width(bf3_pkg::LINE_WIDTH_BITS'(w));
            push_run(4 * MIN_WIDTH + 1, -1, 1'b1);
        end
    endtask

    // Frame starts in mid-row, back to back, and after a partial frame.
    task automatic test_frame_restart();
        write_width(bf3_pkg::LINE_WIDTH_BITS'(6));
        push_run(3 * 6 + 3, -1, 1'b1);
        push_run(3 * 6 + 2, -1, 1'b1);
        push_run(1, -1, 1'b1);
        push_run(1, -1, 1'b1);
        push_run(1, -1, 1'b1);
        push_run(3 * 6, -1, 1'b1);
    endtask

    // Narrow the width while a row is open, past and exactly at the new width.
    task automatic test_shrink_mid_row();
        write_width(bf3_pkg::LINE_WIDTH_BITS'(9));
        push_run(3 * 9 + 6, -1, 1'b1);
        write_width(bf3_pkg::LINE_WIDTH_BITS'(4));
        push_run(3 * 4 + 3, -1, 1'b0);
        write_width(bf3_pkg::LINE_WIDTH_BITS'(3));
        push_run(6, -1, 1'b0);
    endtask

    // Receiver holds off while pixels keep coming, then the sender pauses to drain.
    task automatic test_backpressure();
        write_width(bf3_pkg::LINE_WIDTH_BITS'(4));
        quiet_src     <= 1'b1;
        hold_requests <= hold_requests + 1;
        push_run(20 * 4, -1, 1'b1);
        quiet_src <= 1'b0;
        drain_results();
        push_run(3 * 4, -1, 1'b0);
    endtask

    // Widths above the maximum act as the maximum; a short run ends no row and gives no mean.
    task automatic test_width_ceiling();
        write_width('1);
        push_run(40, -1, 1'b1);
    endtask

    task automatic test_max_width();
        write_width(bf3_pkg::LINE_WIDTH_BITS'(bf3_pkg::MAX_WIDTH));
        push_run(40, -1, 1'b1);
    endtask

    // Random widths and frames; a narrower or equal width may continue the open frame.
    task automatic test_random_frames();
        int   sent;
        int   w_pick;
        int   eff_old;
        int   rows;
        int   n;
        int   i;
        int   r;
        logic carry_on;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            eff_old = active_width();
            r = $urandom_range(0, 99);
            if (r < 65) w_pick = $urandom_range(3, 10);
            else if (r < 85) w_pick = $urandom_range(11, 48);
            else if (r < 92) w_pick = $urandom_range(0, 2);
            else w_pick = $urandom_range(49, 100);
            write_width(bf3_pkg::LINE_WIDTH_BITS'(w_pick));
            carry_on = (active_width() <= eff_old) && ($urandom_range(0, 3) == 0);
            // Mostly whole frames; some are cut short before any mean is due.
            rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(3, 5);
            if (w_pick > 48) rows = 3;
            n = rows * active_width() + $urandom_range(0, active_width() - 1);
            for (i = 0; i < n; i++)
                push_pixel(pick_pixel((i == 0 && !carry_on) || $urandom_range(0, 99) == 0,
                                      -1));
            sent += n;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_stall = 0;
            end else if (sink_stall > 0) begin
                m_ready <= 1'b0;
                sink_stall--;
            end else begin
                m_ready <= 1'b1;
                sink_stall = quiet_sink ? 0 : pick_gap(sink_calm);
            end
        end
    end

    // Compare every accepted result transaction with the oldest expected mean.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mean_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected result, got %p", $time, m_data);
            end else begin
                oldest_mean = mean_queue.pop_front();
                check_field("chan_a_mean", oldest_mean.chan_a_mean, m_data.chan_a_mean);
                check_field("chan_b_mean", oldest_mean.chan_b_mean, m_data.chan_b_mean);
                check_field("chan_c_mean", oldest_mean.chan_c_mean, m_data.chan_c_mean);
                check_field("row_end", 8'(oldest_mean.row_end), 8'(m_data.row_end));
            end
        end
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        quiet_src     <= 1'b0;
        quiet_sink    <= 1'b0;
        hold_requests <= 0;
        // The predictor starts from the reset state of the block.
        width_reg = bf3_pkg::LINE_WIDTH_RESET;
        col_count = 0;
        row_count = 0;
        foreach (window[k]) window[k] = '0;
        foreach (upper_row[k]) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_width();
        test_flat_frames();
        test_width_floor();
        test_frame_restart();
        test_shrink_mid_row();
        test_backpressure();
        test_width_ceiling();
        test_max_width();
        test_random_frames();

        drain_results();
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
